/* design/lshsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky sigmoid Hebbian state update: shared package
// Widths, fixed-point constants, the sigmoid table, item kinds and the
// microprogram (control word layout and read-only program table).
// ----------------------------------------------------------------------------
package lshsu_pkg;

  // Sizes
  localparam int StateSize = 16;
  localparam int IdxW      = $clog2(StateSize);
  localparam int FracBits  = 16;
  localparam int ValW      = 24;
  localparam int UpcW      = 4;
  localparam int MulAW     = 26;
  localparam int MulBW     = 28;
  localparam int ProdW     = MulAW + MulBW;

  // Q.16 gains
  localparam logic signed [MulBW-1:0] KInputGain = 28'sd19661;  // 0.3
  localparam logic signed [MulBW-1:0] KDecay     = 28'sd62259;  // 0.95
  localparam logic signed [MulBW-1:0] KOutGain   = 28'sd6554;   // 0.1
  localparam logic signed [MulBW-1:0] KLearn     = 28'sd655;    // 0.01

  // Sigmoid saturation value and state clamp (+-10.0)
  localparam logic [15:0]        TanhTop       = 16'd32746;
  localparam logic signed [26:0] StateLimit    = 27'sd10 <<< FracBits;
  localparam logic signed [26:0] StateLimitNeg = -(27'sd10 <<< FracBits);

  // Item kinds
  typedef enum logic [1:0] {
    KIND_INPUT  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // Datapath operation of one microstep
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_ACCEPT    = 4'd1,
    OP_PEND_WR   = 4'd2,
    OP_STATE_ADD = 4'd3,
    OP_READ      = 4'd4,
    OP_LOAD      = 4'd5,
    OP_ACT       = 4'd6,
    OP_SIG_SPLIT = 4'd7,
    OP_SIG_LO    = 4'd8,
    OP_SIG_Y     = 4'd9,
    OP_ACC       = 4'd10,
    OP_NS        = 4'd11,
    OP_RETIRE    = 4'd12,
    OP_CLEAR     = 4'd13
  } op_e;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_P_GAIN  = 3'd1,
    MUL_SIG     = 3'd2,
    MUL_S_DECAY = 3'd3,
    MUL_Y_OUT   = 3'd4,
    MUL_Y_LEARN = 3'd5,
    MUL_NS_HEB  = 3'd6
  } mul_e;

  // Sequencing of the microprogram counter
  typedef enum logic [2:0] {
    SEQ_NEXT     = 3'd0,
    SEQ_JUMP     = 3'd1,
    SEQ_DISPATCH = 3'd2,
    SEQ_WAIT_OUT = 3'd3,
    SEQ_LOOP     = 3'd4
  } seq_e;

  typedef struct packed {
    op_e             op;
    mul_e            mul;
    seq_e            seq;
    logic [UpcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic  accept;
    kind_e kind;
    logic  out_free;
    logic  last_elem;
  } stat_t;

  // Microprogram entry points
  localparam logic [UpcW-1:0] UpcIdle   = 4'd0;
  localparam logic [UpcW-1:0] UpcInput  = 4'd1;
  localparam logic [UpcW-1:0] UpcUpdate = 4'd2;
  localparam logic [UpcW-1:0] UpcRead   = 4'd3;
  localparam logic [UpcW-1:0] UpcTick   = 4'd4;
  localparam logic [UpcW-1:0] UpcRetire = 4'd13;
  localparam logic [UpcW-1:0] UpcEnd    = 4'd14;

  // 0.5*tanh(x/2) in Q.16 at steps of 0.5
  function automatic logic [15:0] half_tanh(input logic [4:0] idx);
    logic [15:0] t;
    case (idx)
      5'd0:    t = 16'd0;
      5'd1:    t = 16'd8026;
      5'd2:    t = 16'd15143;
      5'd3:    t = 16'd20813;
      5'd4:    t = 16'd24956;
      5'd5:    t = 16'd27797;
      5'd6:    t = 16'd29660;
      5'd7:    t = 16'd30847;
      5'd8:    t = 16'd31589;
      5'd9:    t = 16'd32048;
      5'd10:   t = 16'd32329;
      5'd11:   t = 16'd32501;
      5'd12:   t = 16'd32606;
      5'd13:   t = 16'd32670;
      5'd14:   t = 16'd32708;
      5'd15:   t = 16'd32732;
      default: t = TanhTop;
    endcase
    return t;
  endfunction

  // Saturate a 25-bit sum to the 24-bit signed range
  function automatic logic signed [ValW-1:0] sat24(input logic signed [ValW:0] v);
    logic signed [ValW-1:0] r;
    if (v[ValW] != v[ValW-1]) begin
      r = v[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end else begin
      r = v[ValW-1:0];
    end
    return r;
  endfunction

  function automatic ctrl_t uword(input op_e op, input mul_e mul, input seq_e seq,
                                  input logic [UpcW-1:0] target);
    ctrl_t w;
    w.op     = op;
    w.mul    = mul;
    w.seq    = seq;
    w.target = target;
    return w;
  endfunction

  // Microprogram: idle/dispatch, three short item routines, then the
  // ten-step per-element loop of a tick and its closing step.
  function automatic ctrl_t ucode(input logic [UpcW-1:0] upc);
    ctrl_t w;
    case (upc)
      4'd0:    w = uword(OP_ACCEPT,    MUL_NONE,    SEQ_DISPATCH, UpcIdle);
      4'd1:    w = uword(OP_PEND_WR,   MUL_NONE,    SEQ_JUMP,     UpcIdle);
      4'd2:    w = uword(OP_STATE_ADD, MUL_NONE,    SEQ_JUMP,     UpcIdle);
      4'd3:    w = uword(OP_READ,      MUL_NONE,    SEQ_WAIT_OUT, UpcIdle);
      4'd4:    w = uword(OP_LOAD,      MUL_P_GAIN,  SEQ_NEXT,     UpcIdle);
      4'd5:    w = uword(OP_ACT,       MUL_NONE,    SEQ_NEXT,     UpcIdle);
      4'd6:    w = uword(OP_SIG_SPLIT, MUL_NONE,    SEQ_NEXT,     UpcIdle);
      4'd7:    w = uword(OP_SIG_LO,    MUL_SIG,     SEQ_NEXT,     UpcIdle);
      4'd8:    w = uword(OP_SIG_Y,     MUL_NONE,    SEQ_NEXT,     UpcIdle);
      4'd9:    w = uword(OP_NOP,       MUL_S_DECAY, SEQ_NEXT,     UpcIdle);
      4'd10:   w = uword(OP_ACC,       MUL_Y_OUT,   SEQ_NEXT,     UpcIdle);
      4'd11:   w = uword(OP_NS,        MUL_Y_LEARN, SEQ_NEXT,     UpcIdle);
      4'd12:   w = uword(OP_NOP,       MUL_NS_HEB,  SEQ_NEXT,     UpcIdle);
      4'd13:   w = uword(OP_RETIRE,    MUL_NONE,    SEQ_LOOP,     UpcTick);
      4'd14:   w = uword(OP_CLEAR,     MUL_NONE,    SEQ_JUMP,     UpcIdle);
      default: w = uword(OP_NOP,       MUL_NONE,    SEQ_JUMP,     UpcIdle);
    endcase
    return w;
  endfunction

endpackage

/* design/leaky_sigmoid_hebbian_state_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky sigmoid Hebbian state update
// Sixteen-entry neuron state vector with a buffered input vector, driven by
// a microcoded sequencer over a datapath with one shared multiplier.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Input, state update and read
// transactions each run a short routine (a read waits further while the output
// register is held). A step tick takes an accepting step, the per-element loop
// through the one shared multiplier for each of the 16 elements and a closing
// step, and is held up while the result side stalls. Results leave through an
// output register, so a read or the last tick result may wait there while the
// next transaction is taken. Values are signed with 16 fraction bits.
// ----------------------------------------------------------------------------
module leaky_sigmoid_hebbian_state_update (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic [lshsu_pkg::IdxW-1:0]         index_i,
  input  logic signed [lshsu_pkg::ValW-1:0]  value_i,
  input  logic                               vector_end_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lshsu_pkg::ValW-1:0]  result_value_o,
  output logic [lshsu_pkg::IdxW-1:0]         result_index_o,
  output logic                               final_result_o
);

  lshsu_pkg::ctrl_t ctrl;
  lshsu_pkg::stat_t stat;

  // Storage
  logic signed [lshsu_pkg::ValW-1:0] state_q [lshsu_pkg::StateSize];
  logic signed [lshsu_pkg::ValW-1:0] pend_q  [lshsu_pkg::StateSize];
  logic [lshsu_pkg::StateSize-1:0]   present_q;
  logic                              loaded_q;
  logic                              clear_q;

  // Item registers
  logic [lshsu_pkg::IdxW-1:0]        addr_q;
  logic signed [lshsu_pkg::ValW-1:0] val_q;
  logic                              vend_q;

  // Datapath registers
  logic signed [lshsu_pkg::ValW-1:0]  s_q;
  logic                               pres_q;
  logic signed [lshsu_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [24:0]                 act_q, act_d;
  logic                               neg_q, satf_q;
  logic [3:0]                         seg_q;
  logic [14:0]                        frac_q;
  logic [15:0]                        lo_q;
  logic signed [16:0]                 y_q, y_d;
  logic signed [41:0]                 acc_q;
  logic signed [25:0]                 ns_q, ns_d;

  // Output register
  logic                              out_valid_q;
  logic signed [lshsu_pkg::ValW-1:0] res_value_q;
  logic [lshsu_pkg::IdxW-1:0]        res_index_q;
  logic                              res_final_q;

  // Combinational helpers
  logic                               accept, out_free, last_elem, read_go, retire_go;
  logic signed [lshsu_pkg::ValW-1:0]  st_rd, pend_rd, st_new, pend_sum, ns_clamped;
  logic signed [lshsu_pkg::MulAW-1:0] mul_a;
  logic signed [lshsu_pkg::MulBW-1:0] mul_b;
  logic signed [lshsu_pkg::ProdW-1:0] sh16, sh32;
  logic [24:0]                        act_mag;
  logic [15:0]                        tab_lo, tab_hi, tab_diff, interp, y_mag;
  logic signed [42:0]                 ns_sum;
  logic signed [26:0]                 ns_new;

  // Handshake and sequencer status
  assign in_stall_o = (ctrl.op != lshsu_pkg::OP_ACCEPT);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_elem  = (addr_q == lshsu_pkg::IdxW'(lshsu_pkg::StateSize - 1));
  assign read_go    = (ctrl.op == lshsu_pkg::OP_READ) && out_free;
  assign retire_go  = (ctrl.op == lshsu_pkg::OP_RETIRE) && out_free;

  assign stat.accept    = accept;
  assign stat.kind      = lshsu_pkg::kind_e'(kind_i);
  assign stat.out_free  = out_free;
  assign stat.last_elem = last_elem;

  lshsu_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Single-address reads of the stores
  assign st_rd   = state_q[addr_q];
  assign pend_rd = pend_q[addr_q];

  // Kind 1 and kind 0 saturating adds
  assign st_new   = lshsu_pkg::sat24({st_rd[lshsu_pkg::ValW-1], st_rd} +
                                     {val_q[lshsu_pkg::ValW-1], val_q});
  assign pend_sum = lshsu_pkg::sat24({pend_rd[lshsu_pkg::ValW-1], pend_rd} +
                                     {{2{val_q[lshsu_pkg::ValW-1]}},
                                      val_q[lshsu_pkg::ValW-1:1]});

  // Shared multiplier operand selection
  always_comb begin
    case (ctrl.mul)
      lshsu_pkg::MUL_P_GAIN: begin
        mul_a = {{2{pend_rd[lshsu_pkg::ValW-1]}}, pend_rd};
        mul_b = lshsu_pkg::KInputGain;
      end
      lshsu_pkg::MUL_SIG: begin
        mul_a = {10'd0, tab_diff};
        mul_b = {13'd0, frac_q};
      end
      lshsu_pkg::MUL_S_DECAY: begin
        mul_a = {{2{s_q[lshsu_pkg::ValW-1]}}, s_q};
        mul_b = lshsu_pkg::KDecay;
      end
      lshsu_pkg::MUL_Y_OUT: begin
        mul_a = {{9{y_q[16]}}, y_q};
        mul_b = lshsu_pkg::KOutGain;
      end
      lshsu_pkg::MUL_Y_LEARN: begin
        mul_a = {{9{y_q[16]}}, y_q};
        mul_b = lshsu_pkg::KLearn;
      end
      lshsu_pkg::MUL_NS_HEB: begin
        mul_a = ns_q;
        mul_b = {prod_q[26], prod_q[26:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Activation: state plus floored 0.3 times pending input where present
  assign sh16  = prod_q >>> 16;
  assign act_d = {s_q[lshsu_pkg::ValW-1], s_q} + (pres_q ? sh16[24:0] : 25'sd0);

  // Sigmoid: magnitude split into segment and fraction
  assign act_mag = act_q[24] ? (25'd0 - act_q) : act_q;

  // Sigmoid: table segment and slope
  assign tab_lo   = lshsu_pkg::half_tanh({1'b0, seg_q});
  assign tab_hi   = lshsu_pkg::half_tanh({1'b0, seg_q} + 5'd1);
  assign tab_diff = tab_hi - tab_lo;

  // Sigmoid: interpolate, hold at the last entry, apply sign
  assign interp = lo_q + prod_q[30:15];
  assign y_mag  = satf_q ? lshsu_pkg::TanhTop : interp;
  assign y_d    = neg_q ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});

  // Leak: floor of (0.95 s + 0.1 y) as one sum
  assign ns_sum = {acc_q[41], acc_q} + {prod_q[41], prod_q[41:0]};
  assign ns_d   = ns_sum[41:16];

  // Hebbian term, then clamp to +-10
  assign sh32   = prod_q >>> 32;
  assign ns_new = {ns_q[25], ns_q} + sh32[26:0];
  always_comb begin
    if (ns_new > lshsu_pkg::StateLimit) begin
      ns_clamped = lshsu_pkg::StateLimit[lshsu_pkg::ValW-1:0];
    end else if (ns_new < lshsu_pkg::StateLimitNeg) begin
      ns_clamped = lshsu_pkg::StateLimitNeg[lshsu_pkg::ValW-1:0];
    end else begin
      ns_clamped = ns_new[lshsu_pkg::ValW-1:0];
    end
  end

  // Control and reset-cleared storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lshsu_pkg::StateSize; i++) begin
        state_q[i] <= '0;
      end
      present_q   <= '0;
      loaded_q    <= 1'b0;
      clear_q     <= 1'b1;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        clear_q <= cfg_wdata_i;
      end
      // drop the output once taken, load it when a result fires
      if (read_go || retire_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        addr_q <= (lshsu_pkg::kind_e'(kind_i) == lshsu_pkg::KIND_TICK) ? '0 : index_i;
      end else if (retire_go) begin
        addr_q <= addr_q + 1'b1;
      end
      case (ctrl.op)
        lshsu_pkg::OP_PEND_WR: begin
          if (!loaded_q) begin
            present_q[addr_q] <= 1'b1;
            if (vend_q) begin
              loaded_q <= 1'b1;
            end
          end
        end
        lshsu_pkg::OP_STATE_ADD: begin
          state_q[addr_q] <= st_new;
        end
        lshsu_pkg::OP_RETIRE: begin
          if (out_free) begin
            state_q[addr_q] <= ns_clamped;
          end
        end
        lshsu_pkg::OP_CLEAR: begin
          if (clear_q) begin
            present_q <= '0;
            loaded_q  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q  <= value_i;
      vend_q <= vector_end_i;
    end
    if (ctrl.mul != lshsu_pkg::MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (read_go) begin
      res_value_q <= st_rd;
      res_index_q <= addr_q;
      res_final_q <= 1'b1;
    end else if (retire_go) begin
      res_value_q <= {{(lshsu_pkg::ValW - 17){y_q[16]}}, y_q};
      res_index_q <= addr_q;
      res_final_q <= last_elem;
    end
    case (ctrl.op)
      lshsu_pkg::OP_PEND_WR: begin
        if (!loaded_q) begin
          pend_q[addr_q] <= val_q;
        end else if (present_q[addr_q]) begin
          pend_q[addr_q] <= pend_sum;
        end
      end
      lshsu_pkg::OP_LOAD: begin
        s_q    <= st_rd;
        pres_q <= present_q[addr_q];
      end
      lshsu_pkg::OP_ACT: begin
        act_q <= act_d;
      end
      lshsu_pkg::OP_SIG_SPLIT: begin
        neg_q  <= act_q[24];
        satf_q <= |act_mag[24:19];
        seg_q  <= act_mag[18:15];
        frac_q <= act_mag[14:0];
      end
      lshsu_pkg::OP_SIG_LO: begin
        lo_q <= tab_lo;
      end
      lshsu_pkg::OP_SIG_Y: begin
        y_q <= y_d;
      end
      lshsu_pkg::OP_ACC: begin
        acc_q <= prod_q[41:0];
      end
      lshsu_pkg::OP_NS: begin
        ns_q <= ns_d;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_value_q;
  assign result_index_o = res_index_q;
  assign final_result_o = res_final_q;

  // A loaded buffer always holds at least one present entry
  a_loaded_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> |present_q)
    else $error("buffer marked loaded with no present entry");

  // A fired result shows up on the output next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_go || retire_go |=> out_valid_o)
    else $error("fired result not presented");

  // An accepted transaction keeps the input side busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

/* design/lshsu_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky sigmoid Hebbian state update: microsequencer
// Microprogram counter with dispatch on item kind, waits on the output
// register and the per-element loop jump; issues one control word a cycle.
// ----------------------------------------------------------------------------
module lshsu_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lshsu_pkg::stat_t stat_i,
  output lshsu_pkg::ctrl_t ctrl_o
);

  logic [lshsu_pkg::UpcW-1:0] upc_q, upc_d, disp_addr;

  // Fetch the control word of the current step
  assign ctrl_o = lshsu_pkg::ucode(upc_q);

  // Entry point of each item routine
  always_comb begin
    case (stat_i.kind)
      lshsu_pkg::KIND_INPUT:  disp_addr = lshsu_pkg::UpcInput;
      lshsu_pkg::KIND_UPDATE: disp_addr = lshsu_pkg::UpcUpdate;
      lshsu_pkg::KIND_TICK:   disp_addr = lshsu_pkg::UpcTick;
      lshsu_pkg::KIND_READ:   disp_addr = lshsu_pkg::UpcRead;
      default:                disp_addr = lshsu_pkg::UpcIdle;
    endcase
  end

  // Select the next step
  always_comb begin
    case (ctrl_o.seq)
      lshsu_pkg::SEQ_NEXT:     upc_d = upc_q + 1'b1;
      lshsu_pkg::SEQ_JUMP:     upc_d = ctrl_o.target;
      lshsu_pkg::SEQ_DISPATCH: upc_d = stat_i.accept ? disp_addr : upc_q;
      lshsu_pkg::SEQ_WAIT_OUT: upc_d = stat_i.out_free ? ctrl_o.target : upc_q;
      lshsu_pkg::SEQ_LOOP: begin
        if (!stat_i.out_free) begin
          upc_d = upc_q;
        end else if (stat_i.last_elem) begin
          upc_d = upc_q + 1'b1;
        end else begin
          upc_d = ctrl_o.target;
        end
      end
      default:                 upc_d = lshsu_pkg::UpcIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= lshsu_pkg::UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  // A tick transaction enters the element loop next
  a_tick_enters_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.accept && stat_i.kind == lshsu_pkg::KIND_TICK |=> upc_q == lshsu_pkg::UpcTick)
    else $error("tick did not enter element loop");

  // Hold the retire step while the output register is blocked
  a_retire_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q == lshsu_pkg::UpcRetire && !stat_i.out_free |=> upc_q == lshsu_pkg::UpcRetire)
    else $error("retire step left while output blocked");

  // Accepting only ever happens in the idle step
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.accept |-> upc_q == lshsu_pkg::UpcIdle)
    else $error("item accepted outside idle step");

endmodule

/* tb/leaky_sigmoid_hebbian_state_update_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky sigmoid Hebbian state update: self-checking testbench
// Drives input, state update, step tick and read transactions through the
// valid/stall ports and keeps its own fixed-point copy of the neuron vector
// and the pending input buffer. Every result is checked in order against
// that copy. The run has a directed part and then four random phases with
// different sender and receiver idling. The buffer-clear register is toggled
// between phases.
// ----------------------------------------------------------------------------
module leaky_sigmoid_hebbian_state_update_test;
  import lshsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint     Q16_0P3  = 19661;
  localparam longint     Q16_0P95 = 62259;
  localparam longint     Q16_0P1  = 6554;
  localparam longint     Q16_0P01 = 655;
  localparam longint     LEVEL_CAP = longint'(10) <<< 16;
  localparam longint     V24_TOP   = 8388607;
  localparam longint     V24_BOT   = -8388608;
  localparam logic signed [23:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] V_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [23:0] value;
    logic [3:0]         index;
    logic               final_flag;
  } neuron_result_t;

  // Block ports
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic               cfg_wdata_i  = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i       = 2'd0;
  logic [3:0]         index_i      = 4'd0;
  logic signed [23:0] value_i      = 24'sd0;
  logic               vector_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic signed [23:0] result_value_o;
  logic [3:0]         result_index_o;
  logic               final_result_o;

  // Neuron model state
  longint neuron_level [16];
  longint pending_level [16];
  bit     pending_held [16];
  bit     vector_loaded;
  bit     clear_mode;

  neuron_result_t expected_outputs [$];
  neuron_result_t result_expected;
  neuron_result_t result_seen;

  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          error_count        = 0;
  int          items_sent         = 0;
  int          ticks_sent         = 0;
  int          reads_sent         = 0;
  int          results_checked    = 0;
  int unsigned cycle_count        = 0;

  leaky_sigmoid_hebbian_state_update DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .vector_end_i   (vector_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .result_index_o (result_index_o),
    .final_result_o (final_result_o)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_outputs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stall the result side at the current rate
  always @(posedge clk_i) begin
    out_stall_i <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_seen.value      = result_value_o;
      result_seen.index      = result_index_o;
      result_seen.final_flag = final_result_o;
      results_checked++;
      if (expected_outputs.size() == 0) begin
        error_count++;
        if (error_count <= 20)
          $display("%0t unexpected result: value %0d index %0d final %0b", $time,
                   result_seen.value, result_seen.index, result_seen.final_flag);
      end else begin
        result_expected = expected_outputs.pop_front();
        if (result_seen !== result_expected) begin
          error_count++;
          if (error_count <= 20)
            $display("%0t mismatch: expected value %0d index %0d final %0b,",
                     $time, result_expected.value, result_expected.index,
                     result_expected.final_flag,
                     " got value %0d index %0d final %0b",
                     result_seen.value, result_seen.index, result_seen.final_flag);
        end
      end
    end
  end

  function automatic longint clip24(input longint v);
    if (v > V24_TOP) return V24_TOP;
    if (v < V24_BOT) return V24_BOT;
    return v;
  endfunction

  // Knots of 0.5*tanh(x/2) in Q.16, x = 0, 0.5, ... 8
  function automatic longint tanh_knot(input longint k);
    case (k)
      0:  return 0;
      1:  return 8026;
      2:  return 15143;
      3:  return 20813;
      4:  return 24956;
      5:  return 27797;
      6:  return 29660;
      7:  return 30847;
      8:  return 31589;
      9:  return 32048;
      10: return 32329;
      11: return 32501;
      12: return 32606;
      13: return 32670;
      14: return 32708;
      15: return 32732;
      default: return 32746;
    endcase
  endfunction

  // sigmoid(act) - 0.5 by table interpolation on |act|, sign restored
  function automatic longint sigmoid_less_half(input longint act);
    longint mag, seg, lo, y;
    mag = (act < 0) ? -act : act;
    seg = mag >>> 15;
    if (seg >= 16) begin
      y = tanh_knot(16);
    end else begin
      lo = tanh_knot(seg);
      y  = lo + (((tanh_knot(seg + 1) - lo) * (mag & 32767)) >>> 15);
    end
    return (act < 0) ? -y : y;
  endfunction

  // Advance the neuron model by one accepted transaction
  task automatic model_transaction(input kind_e kind, input logic [3:0] idx,
                                   input logic signed [23:0] val, input logic vend);
    longint         s, act, y, ns;
    neuron_result_t r;
    case (kind)
      KIND_INPUT: begin
        if (!vector_loaded) begin
          pending_level[idx] = val;
          pending_held[idx]  = 1'b1;
          if (vend) vector_loaded = 1'b1;
        end else if (pending_held[idx]) begin
          pending_level[idx] = clip24(pending_level[idx] + (longint'(val) >>> 1));
        end
      end
      KIND_UPDATE: begin
        neuron_level[idx] = clip24(neuron_level[idx] + longint'(val));
      end
      KIND_READ: begin
        r.value      = neuron_level[idx][23:0];
        r.index      = idx;
        r.final_flag = 1'b1;
        expected_outputs.insert(expected_outputs.size(), r);
      end
      default: begin
        for (int i = 0; i < 16; i++) begin
          s   = neuron_level[i];
          act = s;
          if (pending_held[i]) act += (pending_level[i] * Q16_0P3) >>> 16;
          y  = sigmoid_less_half(act);
          ns = (s * Q16_0P95 + y * Q16_0P1) >>> 16;
          ns += (ns * y * Q16_0P01) >>> 32;
          if (ns > LEVEL_CAP) ns = LEVEL_CAP;
          if (ns < -LEVEL_CAP) ns = -LEVEL_CAP;
          neuron_level[i] = clip24(ns);
          r.value      = y[23:0];
          r.index      = i[3:0];
          r.final_flag = (i == 15);
          expected_outputs.insert(expected_outputs.size(), r);
        end
        if (clear_mode) begin
          for (int i = 0; i < 16; i++) pending_held[i] = 1'b0;
          vector_loaded = 1'b0;
        end
      end
    endcase
  endtask

  // Present one transaction, hold it through stalls, then predict it
  task automatic send_item(input kind_e kind, input logic [3:0] idx,
                           input logic signed [23:0] val, input logic vend);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    index_i      <= idx;
    value_i      <= val;
    vector_end_i <= vend;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_transaction(kind, idx, val, vend);
    items_sent++;
    if (kind == KIND_TICK) ticks_sent++;
    if (kind == KIND_READ) reads_sent++;
  endtask

  // Drop valid and hold off until every expected result is back
  task automatic wait_for_quiet(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_clear_mode(input logic setting);
    wait_for_quiet(20);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= setting;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    clear_mode = setting;
  endtask

  // Mix full-range values with values near the sigmoid's working range
  function automatic logic signed [23:0] pick_value();
    case ($urandom_range(4))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8 << 16)) - (4 <<< 16));
      2: return 24'($signed($urandom_range(0, 40 << 16)) - (20 <<< 16));
      3: return $urandom_range(1) ? V_MAX : V_MIN;
      default: return 24'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  task automatic test_reset_reads();
    send_item(KIND_READ, 4'd0, 24'sd0, 1'b0);
    send_item(KIND_READ, 4'd15, 24'sd0, 1'b0);
    send_item(KIND_READ, 4'd7, V_MAX, 1'b1);
  endtask

  task automatic test_state_saturation();
    send_item(KIND_UPDATE, 4'd0, V_MAX, 1'b0);
    send_item(KIND_UPDATE, 4'd0, 24'sd1, 1'b0);
    send_item(KIND_UPDATE, 4'd1, V_MIN, 1'b0);
    send_item(KIND_UPDATE, 4'd1, -24'sd1, 1'b1);
    send_item(KIND_UPDATE, 4'd2, 24'sd98304, 1'b0);
    send_item(KIND_READ, 4'd0, 24'sd0, 1'b0);
    send_item(KIND_READ, 4'd1, 24'sd0, 1'b0);
  endtask

  // First vector stores as is; an index written twice keeps the last value
  task automatic test_first_vector();
    send_item(KIND_INPUT, 4'd0, V_MAX, 1'b0);
    send_item(KIND_INPUT, 4'd1, V_MIN, 1'b0);
    send_item(KIND_INPUT, 4'd2, 24'sd65536, 1'b0);
    send_item(KIND_INPUT, 4'd2, -24'sd65536, 1'b0);
    send_item(KIND_INPUT, 4'd5, 24'sd12345, 1'b1);
  endtask

  // Later vector adds half with saturation, skips absent entries; then tick
  task automatic test_later_vector_and_tick();
    send_item(KIND_INPUT, 4'd0, V_MAX, 1'b0);
    send_item(KIND_INPUT, 4'd1, V_MIN, 1'b0);
    send_item(KIND_INPUT, 4'd3, 24'sd555, 1'b0);
    send_item(KIND_INPUT, 4'd5, -24'sd1, 1'b1);
    send_item(KIND_TICK, 4'd0, 24'sd0, 1'b0);
    send_item(KIND_TICK, 4'd15, -24'sd1, 1'b1);
    send_item(KIND_READ, 4'd2, V_MIN, 1'b1);
  endtask

  // With clearing off the buffer survives ticks and keeps accumulating
  task automatic test_held_buffer();
    write_clear_mode(1'b0);
    send_item(KIND_INPUT, 4'd4, -24'sd196608, 1'b0);
    send_item(KIND_INPUT, 4'd9, 24'sd131072, 1'b1);
    send_item(KIND_TICK, 4'd0, 24'sd0, 1'b0);
    send_item(KIND_INPUT, 4'd4, 24'sd40000, 1'b0);
    send_item(KIND_TICK, 4'd6, 24'sd0, 1'b0);
    send_item(KIND_READ, 4'd4, 24'sd0, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic clear_setting, input int count);
    int start_count;
    int pick;
    int len;
    write_clear_mode(clear_setting);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    start_count        = items_sent;
    while (items_sent - start_count < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // well-formed: load a vector, nudge some states, tick, maybe read back
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_item(KIND_INPUT, 4'($urandom_range(15)), pick_value(), k == len - 1);
        repeat ($urandom_range(2))
          send_item(KIND_UPDATE, 4'($urandom_range(15)), pick_value(), 1'($urandom_range(1)));
        send_item(KIND_TICK, 4'($urandom_range(15)), 24'($urandom), 1'($urandom_range(1)));
        if ($urandom_range(1))
          send_item(KIND_READ, 4'($urandom_range(15)), 24'($urandom), 1'($urandom_range(1)));
      end else if (pick < 95) begin
        send_item(kind_e'($urandom_range(3)), 4'($urandom_range(15)), pick_value(),
                  1'($urandom_range(1)));
      end else begin
        wait_for_quiet(0);
      end
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      neuron_level[i]  = 0;
      pending_level[i] = 0;
      pending_held[i]  = 1'b0;
    end
    vector_loaded = 1'b0;
    clear_mode    = 1'b1;

    // Hold reset, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_state_saturation();
    test_first_vector();
    test_later_vector_and_tick();
    test_held_buffer();
    test_random_traffic(0, 0, 1'b1, 20);
    test_random_traffic(81, 0, 1'b0, 20);
    test_random_traffic(0, 81, 1'b1, 20);
    test_random_traffic(9, 9, 1'b0, 20);

    wait_for_quiet(30);
    $display("Sent %0d transactions (%0d step ticks, %0d reads), checked %0d results,",
             items_sent, ticks_sent, reads_sent, results_checked);
    $display("under four idling mixes with buffer clearing both on and off.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
